// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared macros for concurrent assertions on a clock and an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define MEXP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define MEXP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/mexp_pkg.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Item types and constants shared by the exponentiation block and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mexp_pkg;

  localparam int MEXP_FIELD_WIDTH = 64;
  localparam int MEXP_DATA_WIDTH  = 64;

  typedef struct packed {
    logic [MEXP_FIELD_WIDTH-1:0] base_value;
    logic [MEXP_FIELD_WIDTH-1:0] exponent;
    logic [MEXP_FIELD_WIDTH-1:0] modulus;
  } mexp_in_t;

  typedef struct packed {
    logic [MEXP_FIELD_WIDTH-1:0] power_residue;
    logic                        bad_modulus;
  } mexp_out_t;

endpackage

// ----- hdl/modular_exponentiation.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation
// Computes base to the power exponent modulo modulus by right-to-left square
// and multiply over one shared modular add-and-double unit.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_ready, in_data) takes one item holding a
// base, an exponent and a modulus; the result channel (out_valid, out_ready,
// out_data) returns one item with the residue and a flag for a zero modulus.
// Only the low DATA_WIDTH bits of each input field are used.
// The block holds one item at a time and drops in_ready from acceptance until
// the residue has been moved to the output register. Every modular product
// runs through a single adder and compare-subtract, one doubling per cycle
// plus an extra add step for each set multiplier bit. An item first reduces
// the base modulo the modulus, then for each bit of the exponent, lowest
// first, multiplies the residue by the base when the bit is set and squares
// the base. A zero modulus goes from acceptance straight to the finish
// state, and a base that reduces to zero goes to finish from the check
// state that follows reduction.
// Synchronous reset returns the sequencer to idle and empties the output.
// While the receiver stalls, the output register holds its item and the next
// item may still be accepted and worked on; it waits at the end if needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modular_exponentiation #(
  parameter int DATA_WIDTH = mexp_pkg::MEXP_DATA_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mexp_pkg::mexp_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mexp_pkg::mexp_out_t out_data
);

  import mexp_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(DATA_WIDTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_LOOP,
    ST_MUL,
    ST_SQR,
    ST_FINISH
  } state_t;

  state_t                state_r;
  logic [DATA_WIDTH-1:0] base_r;
  logic [DATA_WIDTH-1:0] exp_r;
  logic [DATA_WIDTH-1:0] mod_r;
  logic [DATA_WIDTH-1:0] res_r;
  logic                  bad_r;
  logic [DATA_WIDTH-1:0] acc_r;
  logic [DATA_WIDTH-1:0] op_a_r;
  logic [DATA_WIDTH-1:0] mult_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  phase_r;
  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_res_r;
  logic                  out_bad_r;

  logic [DATA_WIDTH-1:0] addend;
  logic [DATA_WIDTH:0]   sum_w;
  logic [DATA_WIDTH:0]   diff_w;
  logic [DATA_WIDTH-1:0] step_res;
  logic                  mult_bit;
  logic                  step_last;
  logic                  in_fire;

  // The shared unit adds two residues and folds the sum back below the modulus.
  assign addend   = phase_r ? op_a_r : acc_r;
  assign sum_w    = {1'b0, acc_r} + {1'b0, addend};
  assign diff_w   = sum_w - {1'b0, mod_r};
  assign step_res = diff_w[DATA_WIDTH] ? sum_w[DATA_WIDTH-1:0] : diff_w[DATA_WIDTH-1:0];

  assign mult_bit  = mult_r[DATA_WIDTH-1];
  assign step_last = (cnt_r == LAST_BIT) && (phase_r || !mult_bit);

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign out_valid              = out_valid_r;
  assign out_data.power_residue = MEXP_FIELD_WIDTH'(out_res_r);
  assign out_data.bad_modulus   = out_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      // One step of add-and-double: double always, then add when the bit is set.
      if (state_r == ST_REDUCE || state_r == ST_MUL || state_r == ST_SQR) begin
        acc_r <= step_res;
        if (!phase_r && mult_bit) begin
          phase_r <= 1'b1;
        end else begin
          phase_r <= 1'b0;
          mult_r  <= {mult_r[DATA_WIDTH-2:0], 1'b0};
          cnt_r   <= cnt_r + CNT_W'(1);
        end
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            base_r  <= in_data.base_value[DATA_WIDTH-1:0];
            exp_r   <= in_data.exponent[DATA_WIDTH-1:0];
            mod_r   <= in_data.modulus[DATA_WIDTH-1:0];
            res_r   <= DATA_WIDTH'(1);
            bad_r   <= 1'b0;
            acc_r   <= '0;
            op_a_r  <= DATA_WIDTH'(1);
            mult_r  <= in_data.base_value[DATA_WIDTH-1:0];
            cnt_r   <= '0;
            phase_r <= 1'b0;
            if (in_data.modulus[DATA_WIDTH-1:0] == '0) begin
              res_r   <= '0;
              bad_r   <= 1'b1;
              state_r <= ST_FINISH;
            end else begin
              state_r <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          if (step_last) begin
            base_r  <= step_res;
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (base_r == '0) begin
            res_r   <= '0;
            state_r <= ST_FINISH;
          end else begin
            state_r <= ST_LOOP;
          end
        end
        ST_LOOP: begin
          acc_r   <= '0;
          op_a_r  <= base_r;
          cnt_r   <= '0;
          phase_r <= 1'b0;
          if (exp_r == '0) begin
            state_r <= ST_FINISH;
          end else if (exp_r[0]) begin
            mult_r  <= res_r;
            state_r <= ST_MUL;
          end else begin
            mult_r  <= base_r;
            state_r <= ST_SQR;
          end
        end
        ST_MUL: begin
          if (step_last) begin
            res_r   <= step_res;
            acc_r   <= '0;
            mult_r  <= base_r;
            cnt_r   <= '0;
            phase_r <= 1'b0;
            state_r <= ST_SQR;
          end
        end
        ST_SQR: begin
          if (step_last) begin
            base_r  <= step_res;
            exp_r   <= {1'b0, exp_r[DATA_WIDTH-1:1]};
            state_r <= ST_LOOP;
          end
        end
        ST_FINISH: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_res_r   <= res_r;
            out_bad_r   <= bad_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/mexp_checker.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation checker
// Port-level assertions on the exponentiation block, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mexp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input mexp_pkg::mexp_in_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input mexp_pkg::mexp_out_t out_data
);

  import mexp_pkg::*;

  logic in_fire;
  logic out_stall;

  assign in_fire   = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  `MEXP_ASSERT(a_out_hold, clk, rst_n, out_stall |=> out_valid, "result item dropped while stalled")
  `MEXP_ASSERT(a_out_stable, clk, rst_n, out_stall |=> $stable(out_data), "result item changed while stalled")
  `MEXP_ASSERT(a_bad_zero, clk, rst_n, (out_valid && out_data.bad_modulus) |-> (out_data.power_residue == '0), "zero modulus must give a zero residue")
  `MEXP_ASSERT(a_busy_after_accept, clk, rst_n, in_fire |=> !in_ready, "block must be busy after taking an item")
  `MEXP_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> (!out_valid && in_ready), "reset must empty the block")

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (.*);
